// ===== hdl/can_bitrate_autodetect_scanner_core_defines.svh =====
// ----------------------------------------------------------------------------
// Scanner assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef CAN_BITRATE_AUTODETECT_SCANNER_CORE_DEFINES_SVH
`define CAN_BITRATE_AUTODETECT_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CBAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbas_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitrate scanner package
// Request and result codes, register indexes and the probe order table.
// ----------------------------------------------------------------------------
package cbas_pkg;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned NumSteps  = 8;
  localparam int unsigned StepW     = $clog2(NumSteps);

  localparam logic [CfgIdxW-1:0] CfgDwellMs   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMinFrames = 1'd1;

  localparam logic [15:0] DwellReset     = 16'd250;
  localparam logic [7:0]  MinFramesReset = 8'd2;
  localparam logic [15:0] DwellMax       = 16'hFFFF;
  localparam logic [7:0]  FrameMax       = 8'd255;

  typedef enum logic [1:0] {
    ReqStart  = 2'd0,
    ReqCancel = 2'd1,
    ReqFrame  = 2'd2,
    ReqTick   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KindProbe   = 3'd0,
    KindFound   = 3'd1,
    KindFailed  = 3'd2,
    KindRefused = 3'd3,
    KindCancel  = 3'd4
  } kind_e;

  // Probe order: 6, 4, 5, 8, 3, 2, 1, 0.
  function automatic logic [3:0] probe_code(input logic [StepW-1:0] step);
    logic [3:0] code;
    case (step)
      3'd0:    code = 4'd6;
      3'd1:    code = 4'd4;
      3'd2:    code = 4'd5;
      3'd3:    code = 4'd8;
      3'd4:    code = 4'd3;
      3'd5:    code = 4'd2;
      3'd6:    code = 4'd1;
      default: code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/can_bitrate_autodetect_scanner_core.sv =====
// ----------------------------------------------------------------------------
// CAN bitrate scanner core
// Event-driven probe of eight bitrate codes with frame scoring per dwell.
// ----------------------------------------------------------------------------
// Takes one event transaction per cycle while the input is not stalled. Each
// transaction is captured in an input register, the scan state is updated by
// one pass of compare and increment logic, and the result (if any) lands in an
// output register. Throughput is one event per clock while results are taken,
// limited only by the single-pass update; the input side keeps accepting while a
// result waits, and stalls only when both registers are full. Write dwell_ms
// (index 0) and min_frames (index 1) while no scan is running.
module can_bitrate_autodetect_scanner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cbas_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [cbas_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic                            bus_error_i,
  input  logic                            channel_open_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      result_kind_o,
  output logic [3:0]                      bitrate_code_o
);
  import cbas_pkg::*;

`include "can_bitrate_autodetect_scanner_core_defines.svh"

  // configuration
  logic [15:0] dwell_ms_q;
  logic [7:0]  min_frames_q;

  // input register
  logic        in_valid_q;
  req_e        req_type_q;
  logic        bus_error_q;
  logic        channel_open_q;

  // scan state
  logic             scan_active_q, scan_active_d;
  logic [StepW-1:0] step_index_q, step_index_d;
  logic [15:0]      dwell_count_q, dwell_count_d;
  logic [7:0]       frame_count_q, frame_count_d;
  logic [8:0]       lead_score_q, lead_score_d;
  logic [3:0]       lead_code_q, lead_code_d;

  // output register
  logic        out_valid_q;
  kind_e       kind_q;
  logic [3:0]  code_q;

  logic        res_valid;
  kind_e       res_kind;
  logic [3:0]  res_code;

  logic        proc;
  logic        in_accept;
  logic [15:0] dwell_inc;
  logic [8:0]  score;
  logic        dwell_done;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;
  assign in_accept  = in_valid_i && in_ready_o;

  assign dwell_inc  = (dwell_count_q == DwellMax) ? dwell_count_q : dwell_count_q + 16'd1;
  assign dwell_done = dwell_inc >= dwell_ms_q;
  assign score      = {!bus_error_q, frame_count_q};

  always_comb begin
    scan_active_d = scan_active_q;
    step_index_d  = step_index_q;
    dwell_count_d = dwell_count_q;
    frame_count_d = frame_count_q;
    lead_score_d  = lead_score_q;
    lead_code_d   = lead_code_q;
    res_valid     = 1'b0;
    res_kind      = KindProbe;
    res_code      = 4'd0;
    case (req_type_q)
      ReqStart: begin
        res_valid = 1'b1;
        if (channel_open_q || scan_active_q) begin
          res_kind = KindRefused;
        end else begin
          scan_active_d = 1'b1;
          step_index_d  = '0;
          dwell_count_d = '0;
          frame_count_d = '0;
          lead_score_d  = '0;
          lead_code_d   = '0;
          res_code      = probe_code('0);
        end
      end
      ReqCancel: begin
        scan_active_d = 1'b0;
        step_index_d  = '0;
        dwell_count_d = '0;
        frame_count_d = '0;
        lead_score_d  = '0;
        lead_code_d   = '0;
        res_valid     = 1'b1;
        res_kind      = KindCancel;
      end
      ReqFrame: begin
        if (scan_active_q && frame_count_q != FrameMax) begin
          frame_count_d = frame_count_q + 8'd1;
        end
      end
      ReqTick: begin
        if (scan_active_q) begin
          dwell_count_d = dwell_inc;
          if (dwell_done) begin
            res_valid = 1'b1;
            if (frame_count_q >= min_frames_q && score > lead_score_q) begin
              lead_score_d = score;
              lead_code_d  = probe_code(step_index_q);
            end
            if (step_index_q != StepW'(NumSteps - 1)) begin
              // advance to the next candidate
              step_index_d  = step_index_q + StepW'(1);
              frame_count_d = '0;
              dwell_count_d = '0;
              res_code      = probe_code(step_index_q + StepW'(1));
            end else begin
              scan_active_d = 1'b0;
              step_index_d  = '0;
              if (lead_score_d != '0) begin
                res_kind = KindFound;
                res_code = lead_code_d;
              end else begin
                res_kind = KindFailed;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ms_q     <= DwellReset;
      min_frames_q   <= MinFramesReset;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      scan_active_q  <= 1'b0;
      step_index_q   <= '0;
      dwell_count_q  <= '0;
      frame_count_q  <= '0;
      lead_score_q   <= '0;
      lead_code_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDwellMs:   dwell_ms_q   <= cfg_data_i;
          CfgMinFrames: min_frames_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q   <= res_valid;
        scan_active_q <= scan_active_d;
        step_index_q  <= step_index_d;
        dwell_count_q <= dwell_count_d;
        frame_count_q <= frame_count_d;
        lead_score_q  <= lead_score_d;
        lead_code_q   <= lead_code_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_type_q     <= req_e'(req_type_i);
      bus_error_q    <= bus_error_i;
      channel_open_q <= channel_open_i;
    end
    if (proc && res_valid) begin
      kind_q <= res_kind;
      code_q <= res_code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign bitrate_code_o = code_q;

  `CBAS_ASSERT_NOW(a_idle_step_zero, !scan_active_q, step_index_q == '0, "idle scanner holds a step")
  `CBAS_ASSERT_NOW(a_stall_only_full, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled with room")
  `CBAS_ASSERT_NEXT(a_busy_start_refused, proc && req_type_q == ReqStart && scan_active_q, out_valid_q && kind_q == KindRefused, "start during scan not refused")
  `CBAS_ASSERT_NEXT(a_cancel_stops, proc && req_type_q == ReqCancel, !scan_active_q && out_valid_q && kind_q == KindCancel, "cancel left scan running")
  `CBAS_ASSERT_NEXT(a_probe_while_active, proc && res_valid && res_kind == KindProbe, scan_active_q, "probe reported with scan stopped")

endmodule
